/* rtl/rwvc_pkg.sv */
package rwvc_pkg;

  localparam int KIND_W = 3;
  localparam int NODE_W = 16;
  localparam int EIDX_W = 20;
  localparam int DEG_W = 21;
  localparam int RAND_W = 31;
  localparam int NCNT_W = 17;
  localparam int WLEN_W = 20;
  localparam int VIS_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_ROW = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STEP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DAMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NCNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WLEN = 2'd2;

  localparam logic [30:0] DAMP_RST = 31'd322122547;
  localparam logic [NCNT_W-1:0] NCNT_RST = 17'd65536;
  localparam logic [WLEN_W-1:0] WLEN_RST = 20'd32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROWRD,
    ST_ROWWAIT,
    ST_DIV,
    ST_EDGERD,
    ST_EDGEWAIT,
    ST_CNTRD,
    ST_CNTWAIT,
    ST_CNTWR,
    ST_RDWAIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;     // write zero to visit count at sweep address, advance sweep
    logic load_in;      // capture input item
    logic row_wr;
    logic edge_wr;
    logic start_walk;
    logic row_rd;
    logic div_start;    // choose source and start modulo
    logic edge_rd;
    logic edge_cap;
    logic tele_cap;     // take the teleport node from the remainder
    logic cnt_rd;       // read count of next node
    logic cnt_wr;       // write back incremented count, emit result
    logic rd_rd;        // read count of the read node
    logic rd_out;       // emit read result
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    logic div_busy;
    logic teleport;
    logic walk_live;
    logic [KIND_W-1:0] kind;
  } sts_t;

endpackage

/* rtl/rwvc_ram.sv */
module rwvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rwvc_div.sv */
module rwvc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] dividend,
  input  logic [20:0] divisor,
  output logic        busy,
  output logic [20:0] rem
);

  // Restoring division, one quotient bit per cycle.
  logic [21:0] rem_r, rem_nxt;
  logic [30:0] dvd_r, dvd_nxt;
  logic [20:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [21:0] shifted;

  assign shifted = {rem_r[20:0], dvd_r[30]};

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = 5'd30;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[29:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
      end else begin
        rem_nxt = shifted;
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign rem = rem_r[20:0];

endmodule

/* rtl/rwvc_ctrl.sv */
module rwvc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rwvc_pkg::sts_t sts,
  output rwvc_pkg::ctl_t ctl
);
  import rwvc_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          case (sts.kind)
            KIND_STEP: state_nxt = ST_ROWRD;
            KIND_READ: state_nxt = ST_RDWAIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ROWRD:    state_nxt = sts.walk_live ? ST_ROWWAIT : ST_IDLE;
      ST_ROWWAIT:  state_nxt = ST_DIV;
      ST_DIV:      state_nxt = ST_EDGERD;
      ST_EDGERD:   if (!sts.div_busy) state_nxt = sts.teleport ? ST_CNTRD : ST_EDGEWAIT;
      ST_EDGEWAIT: state_nxt = ST_CNTRD;
      ST_CNTRD:    state_nxt = ST_CNTWAIT;
      ST_CNTWAIT:  state_nxt = ST_CNTWR;
      ST_CNTWR:    state_nxt = ST_IDLE;
      ST_RDWAIT:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: ctl.clr_step = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load_in = 1'b1;
          case (sts.kind)
            KIND_ROW:   ctl.row_wr = 1'b1;
            KIND_EDGE:  ctl.edge_wr = 1'b1;
            KIND_START: ctl.start_walk = 1'b1;
            KIND_READ:  ctl.rd_rd = 1'b1;
            default:    ;
          endcase
        end
      end
      ST_ROWRD:    ctl.row_rd = 1'b1;
      ST_DIV:      ctl.div_start = 1'b1;
      ST_EDGERD: begin
        if (!sts.div_busy) begin
          if (sts.teleport) ctl.tele_cap = 1'b1;
          else ctl.edge_rd = 1'b1;
        end
      end
      ST_EDGEWAIT: ctl.edge_cap = 1'b1;
      ST_CNTRD:    ctl.cnt_rd = 1'b1;
      ST_CNTWR:    ctl.cnt_wr = 1'b1;
      ST_RDWAIT:   ctl.rd_out = 1'b1;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rwvc_dp.sv */
module rwvc_dp #(
  parameter int MAX_NODES = 65536,
  parameter int MAX_EDGES = 1048576,
  parameter int COUNT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rwvc_pkg::ctl_t                  ctl,
  output rwvc_pkg::sts_t                  sts,
  input  logic [rwvc_pkg::KIND_W-1:0]     in_kind,
  input  logic [rwvc_pkg::NODE_W-1:0]     in_node,
  input  logic [rwvc_pkg::EIDX_W-1:0]     in_edge_index,
  input  logic [rwvc_pkg::DEG_W-1:0]      in_degree,
  input  logic [rwvc_pkg::NODE_W-1:0]     in_target,
  input  logic [rwvc_pkg::RAND_W-1:0]     in_rand_jump,
  input  logic [rwvc_pkg::RAND_W-1:0]     in_rand_pick,
  input  logic [30:0]                     damp,
  input  logic [rwvc_pkg::NCNT_W-1:0]     ncnt,
  input  logic [rwvc_pkg::WLEN_W-1:0]     wlen,
  output logic                            out_valid,
  output logic [rwvc_pkg::NODE_W-1:0]     out_visited_node,
  output logic [rwvc_pkg::VIS_W-1:0]      out_visits,
  output logic                            out_walk_done
);
  import rwvc_pkg::*;

  localparam int NA = $clog2(MAX_NODES);
  localparam int EA = $clog2(MAX_EDGES);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam int NCAP = (MAX_NODES < 65536) ? MAX_NODES : 65536;

  logic [NA-1:0] node_r, cur_r, nxt_r, clr_r, cnt_addr;
  logic [NODE_W-1:0] rnode_r;
  logic node_ok_r;
  logic [RAND_W-1:0] pick_r, jump_r;
  logic [WLEN_W-1:0] left_r;
  logic tele_r;
  logic tele_now;
  logic clr_done_r;
  logic [20:0] div_dvs;
  logic [20:0] rem;
  logic [NA-1:0] rem_node;
  logic div_busy;
  logic [EIDX_W-1:0] first_q;
  logic [DEG_W-1:0] deg_q;
  logic [NODE_W-1:0] tgt_q;
  logic [COUNT_BITS-1:0] cnt_q, cnt_inc;
  logic [EIDX_W+1:0] esum;
  logic [16:0] eff_n;

  // Node indices wrap modulo MAX_NODES (a power of two).
  function automatic logic [NA-1:0] nidx(input logic [NODE_W-1:0] n);
    logic [NODE_W+NA:0] w;
    w = {{(NA+1){1'b0}}, n};
    return w[NA-1:0];
  endfunction

  always_comb begin
    eff_n = ncnt;
    if (ncnt == '0) eff_n = 17'd1;
    if (32'(ncnt) > NCAP) eff_n = 17'(NCAP);
  end

  // The row data is valid in the cycle of div_start, so the teleport decision
  // and the modulus are taken from it directly.
  assign tele_now = (jump_r < damp) || (deg_q == '0);
  assign div_dvs = tele_now ? {4'd0, eff_n} : deg_q;

  rwvc_div u_div (
    .clk, .rst_n,
    .start(ctl.div_start),
    .dividend(pick_r),
    .divisor(div_dvs),
    .busy(div_busy),
    .rem(rem)
  );

  always_comb begin
    logic [20+NA:0] t;
    t = {{NA{1'b0}}, rem};
    rem_node = t[NA-1:0];
  end

  rwvc_ram #(.WIDTH(EIDX_W), .DEPTH(MAX_NODES)) u_first (
    .clk, .we(ctl.row_wr && (32'(in_node) < MAX_NODES)), .waddr(nidx(in_node)),
    .wdata(in_edge_index), .raddr(cur_r), .rdata(first_q));
  rwvc_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg (
    .clk, .we(ctl.row_wr && (32'(in_node) < MAX_NODES)), .waddr(nidx(in_node)),
    .wdata(in_degree), .raddr(cur_r), .rdata(deg_q));

  logic [EA-1:0] e_waddr, e_raddr;
  logic [EIDX_W+EA:0] ew;
  assign ew = {{(EA+1){1'b0}}, in_edge_index};
  assign e_waddr = ew[EA-1:0];
  assign esum = {2'b0, first_q} + {1'b0, rem};
  always_comb begin
    logic [EIDX_W+EA+1:0] t;
    t = {{EA{1'b0}}, esum};
    e_raddr = t[EA-1:0];
  end
  rwvc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(ctl.edge_wr && (32'(in_edge_index) < MAX_EDGES)), .waddr(e_waddr),
    .wdata(in_target), .raddr(e_raddr), .rdata(tgt_q));

  // Count memory: written by the clearing sweep or the step write-back.
  assign cnt_addr = ctl.rd_rd ? nidx(in_node) : nxt_r;
  assign cnt_inc = (cnt_q == CMAX) ? cnt_q : cnt_q + 1'b1;
  rwvc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_NODES)) u_cnt (
    .clk, .we(ctl.clr_step || ctl.cnt_wr), .waddr(ctl.clr_step ? clr_r : nxt_r),
    .wdata(ctl.clr_step ? '0 : cnt_inc), .raddr(cnt_addr), .rdata(cnt_q));

  function automatic logic [VIS_W-1:0] sat(input logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? '1 : w[VIS_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_done_r <= 1'b0;
      cur_r <= '0;
      left_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.cnt_wr || ctl.rd_out;
      if (ctl.clr_step) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == NA'(MAX_NODES - 1)) clr_done_r <= 1'b1;
      end
      if (ctl.start_walk) begin
        cur_r <= nidx(in_node);
        left_r <= wlen;
      end
      if (ctl.cnt_wr) begin
        cur_r <= nxt_r;
        left_r <= left_r - 1'b1;
      end
    end
    if (ctl.load_in) begin
      node_r <= nidx(in_node);
      rnode_r <= in_node;
      node_ok_r <= 32'(in_node) < MAX_NODES;
      pick_r <= in_rand_pick;
      jump_r <= in_rand_jump;
    end
    if (ctl.div_start) tele_r <= tele_now;
    if (ctl.tele_cap) begin
      nxt_r <= rem_node;
    end else if (ctl.edge_cap) begin
      nxt_r <= nidx(tgt_q);
    end
    if (ctl.cnt_wr) begin
      out_visited_node <= NODE_W'(nxt_r);
      out_visits <= sat(cnt_inc);
      out_walk_done <= (left_r == WLEN_W'(1));
    end
    if (ctl.rd_out) begin
      out_visited_node <= rnode_r;
      out_visits <= node_ok_r ? sat(cnt_q) : '0;
      out_walk_done <= 1'b0;
    end
  end

  assign sts.clr_done = clr_done_r;
  assign sts.div_busy = div_busy || ctl.div_start;
  assign sts.teleport = tele_r;
  assign sts.walk_live = left_r != '0;
  assign sts.kind = in_kind;

  logic unused;
  assign unused = ^{node_r, ctl.row_rd, ctl.edge_rd, ctl.cnt_rd};

endmodule

/* rtl/random_walk_visit_counter_top.sv */
// Monte Carlo PageRank walker. After reset a clearing pass zeroes the visit
// counts of all MAX_NODES nodes (65536 by default), one node per cycle, with
// busy high. Loads, starts and unused kinds are handled in the idle state
// without raising busy. A step reads the row, runs the bit-serial modulo by
// the degree or node count, reads the edge memory unless it teleports, then
// reads the count and writes it back incremented. A step outside a walk
// returns to idle without a result; a count read emits it from ST_RDWAIT.
// Each result is on the out_ ports for one cycle with out_valid high, in the
// cycle in which busy returns low; the receiver cannot stall it.
module random_walk_visit_counter_top #(
  parameter int MAX_NODES = 65536,
  parameter int MAX_EDGES = 1048576,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rwvc_pkg::KIND_W-1:0]         in_kind,
  input  logic [rwvc_pkg::NODE_W-1:0]         in_node,
  input  logic [rwvc_pkg::EIDX_W-1:0]         in_edge_index,
  input  logic [rwvc_pkg::DEG_W-1:0]          in_degree,
  input  logic [rwvc_pkg::NODE_W-1:0]         in_target,
  input  logic [rwvc_pkg::RAND_W-1:0]         in_rand_jump,
  input  logic [rwvc_pkg::RAND_W-1:0]         in_rand_pick,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rwvc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data,
  output logic                                out_valid,
  output logic [rwvc_pkg::NODE_W-1:0]         out_visited_node,
  output logic [rwvc_pkg::VIS_W-1:0]          out_visits,
  output logic                                out_walk_done
);
  import rwvc_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [30:0] damp_r;
  logic [NCNT_W-1:0] ncnt_r;
  logic [WLEN_W-1:0] wlen_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r <= DAMP_RST;
      ncnt_r <= NCNT_RST;
      wlen_r <= WLEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DAMP: damp_r <= cfg_data[30:0];
        REG_NCNT: ncnt_r <= cfg_data[NCNT_W-1:0];
        REG_WLEN: wlen_r <= cfg_data[WLEN_W-1:0];
        default:  ;
      endcase
    end
  end

  rwvc_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .ctl);

  rwvc_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .in_kind, .in_node, .in_edge_index, .in_degree, .in_target,
    .in_rand_jump, .in_rand_pick,
    .damp(damp_r), .ncnt(ncnt_r), .wlen(wlen_r),
    .out_valid, .out_visited_node, .out_visits, .out_walk_done);

endmodule

/* rtl/rwvc_chk.sv */
module rwvc_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_walk_done
);

  // A transfer is accepted only when idle, so results never come back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back results");

  // The done flag only changes together with a result.
  a_done_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_walk_done) |-> out_valid) else $error("walk_done without result");

  a_busy_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> busy) else $error("not busy during clearing pass");

  // Every result ends a busy period.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a busy period");

  logic unused;
  assign unused = start;

endmodule

bind random_walk_visit_counter_top rwvc_chk u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_walk_done);
